>>> sv/cartesian_to_polar_degrees_unit_macros.svh
// Assertion macros shared by the RTL of the polar conversion unit.
// Define NO_ASSERTIONS to compile them away.
`ifndef CARTESIAN_TO_POLAR_DEGREES_UNIT_MACROS_SVH
`define CARTESIAN_TO_POLAR_DEGREES_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define C2P_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define C2P_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define C2P_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define C2P_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> sv/c2p_pkg.sv
`timescale 1ns / 1ps
package c2p_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 8;

	// Fixed field widths of the stream payload.
	localparam int COORD_FIELD_W = 16;
	localparam int RADIUS_W      = 24;
	localparam int ANGLE_W       = 17;
	localparam int IN_TDATA_W    = ((2 * COORD_FIELD_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W   = ((RADIUS_W + ANGLE_W + 7) / 8) * 8;

	// Rotation datapath.
	localparam int CORDIC_STEPS    = 21;
	localparam int CORDIC_PRESHIFT = 20;
	localparam int ANG_FRAC        = 16;
	localparam int CORD_W          = COORD_WIDTH + CORDIC_PRESHIFT + 3;
	localparam int ACC_W           = ANG_FRAC + 9;
	localparam int TOT_W           = ANG_FRAC + 9;

	// Square root datapath: one result bit per cell.
	localparam int ROOT_W = COORD_WIDTH + FRAC_BITS;
	localparam int SQ_W   = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;

	localparam int NCELL = (ROOT_W > CORDIC_STEPS) ? ROOT_W : CORDIC_STEPS;
	localparam int IDX_W = $clog2(NCELL);

	// Angle rounding from ANG_FRAC down to FRAC_BITS fraction bits.
	localparam int RND_SH = ANG_FRAC - FRAC_BITS;
	localparam int RND_W  = TOT_W + 1 - RND_SH;
	localparam logic [TOT_W:0] RND_HALF = (RND_SH == 0) ? '0 : (TOT_W + 1)'(1) << (RND_SH - 1);

	localparam logic signed [ACC_W-1:0] ACC_DEG90 = ACC_W'(90 << ANG_FRAC);
	localparam logic [TOT_W-1:0] TOT_DEG180 = TOT_W'(180 << ANG_FRAC);
	localparam logic [TOT_W-1:0] TOT_DEG360 = TOT_W'(360 << ANG_FRAC);
	localparam logic [RND_W-1:0] OUT_DEG360 = RND_W'(360 << FRAC_BITS);
	localparam logic [ANGLE_W-1:0] OUT_DEG90  = ANGLE_W'(90 << FRAC_BITS);
	localparam logic [ANGLE_W-1:0] OUT_DEG270 = ANGLE_W'(270 << FRAC_BITS);

	typedef struct packed {
		logic x_zero;
		logic x_neg;
		logic y_zero;
		logic y_neg;
		logic origin;
	} c2p_flags_t;

	// Everything one cell hands to its neighbor.
	typedef struct packed {
		logic signed [CORD_W-1:0] cx;
		logic signed [CORD_W-1:0] cy;
		logic signed [ACC_W-1:0]  acc;
		logic [SQ_W-1:0]          sq_bits;
		logic [REM_W-1:0]         rem;
		logic [ROOT_W-1:0]        root;
		c2p_flags_t               flags;
	} c2p_cell_t;

	// atan(2^-i) in degrees with ANG_FRAC fraction bits.
	function automatic logic signed [ACC_W-1:0] atan_deg(input logic [IDX_W-1:0] i);
		logic signed [ACC_W-1:0] v;
		unique case (i)
			IDX_W'(0):  v = ACC_W'(2949120);
			IDX_W'(1):  v = ACC_W'(1740967);
			IDX_W'(2):  v = ACC_W'(919879);
			IDX_W'(3):  v = ACC_W'(466945);
			IDX_W'(4):  v = ACC_W'(234379);
			IDX_W'(5):  v = ACC_W'(117304);
			IDX_W'(6):  v = ACC_W'(58666);
			IDX_W'(7):  v = ACC_W'(29335);
			IDX_W'(8):  v = ACC_W'(14668);
			IDX_W'(9):  v = ACC_W'(7334);
			IDX_W'(10): v = ACC_W'(3667);
			IDX_W'(11): v = ACC_W'(1833);
			IDX_W'(12): v = ACC_W'(917);
			IDX_W'(13): v = ACC_W'(458);
			IDX_W'(14): v = ACC_W'(229);
			IDX_W'(15): v = ACC_W'(115);
			IDX_W'(16): v = ACC_W'(57);
			IDX_W'(17): v = ACC_W'(29);
			IDX_W'(18): v = ACC_W'(14);
			IDX_W'(19): v = ACC_W'(7);
			IDX_W'(20): v = ACC_W'(4);
			default:    v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> sv/cartesian_to_polar_degrees_unit.sv
// Converts a signed point (x, y) into its radius and its angle in degrees in [0, 360),
// both unsigned with eight fraction bits. One point is taken in every cycle unless the output
// stalls, and each result passes through three entry stages (magnitudes, squares, start
// values), a chain of 24 identical cells that each produce one bit of the square root, the
// first 21 of them also performing one CORDIC micro-rotation, and two finishing stages for
// the quadrant mapping and rounding. Backpressure stalls only the stages that hold data, so
// bubbles close up while the output waits. The origin yields zero radius and angle with the
// error flag set in tuser.
`timescale 1ns / 1ps
`include "cartesian_to_polar_degrees_unit_macros.svh"
module cartesian_to_polar_degrees_unit
	import c2p_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// x_coord [15:0], y_coord [31:16]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// radius [23:0], angle_deg [40:24], zero fill above
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// origin_error [0]
	output logic                   m_axis_tuser
);

	logic signed [COORD_WIDTH-1:0] xs;
	logic signed [COORD_WIDTH-1:0] ys;

	logic                   vld_s1, vld_s2, vld_s3, vld_s28, vld_s29;
	logic                   rdy_s1, rdy_s2, rdy_s3, rdy_s28, rdy_s29;
	logic [COORD_WIDTH-1:0] ax_s1, ay_s1, ax_s2, ay_s2;
	c2p_flags_t             flg_s1, flg_s2, flg_s28;
	logic [2*COORD_WIDTH-1:0] sqx_s2, sqy_s2;
	c2p_cell_t              data_s3;
	c2p_cell_t              init;

	logic                   cell_valid [NCELL+1];
	logic                   cell_ready [NCELL+1];
	c2p_cell_t              cell_data  [NCELL+1];

	c2p_cell_t              last;
	logic [TOT_W-1:0]       t_clamp;
	logic [TOT_W-1:0]       total;
	logic [RADIUS_W-1:0]    rad_rnd;
	logic [TOT_W-1:0]       tot_s28;
	logic [RADIUS_W-1:0]    rad_s28;

	logic [TOT_W:0]         tot_half;
	logic [RND_W-1:0]       ang_rnd;
	logic [RND_W-1:0]       ang_wrap;
	logic [ANGLE_W-1:0]     ang_fin;
	logic [RADIUS_W-1:0]    radius_s29;
	logic [ANGLE_W-1:0]     angle_s29;
	logic                   err_s29;

	// Ready travels back through every stage; a stage with no data always accepts.
	assign rdy_s29       = !vld_s29 || m_axis_tready;
	assign rdy_s28       = !vld_s28 || rdy_s29;
	assign rdy_s3        = !vld_s3 || cell_ready[0];
	assign rdy_s2        = !vld_s2 || rdy_s3;
	assign rdy_s1        = !vld_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	assign xs = s_axis_tdata[COORD_WIDTH-1:0];
	assign ys = s_axis_tdata[COORD_FIELD_W +: COORD_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s28 <= 1'b0;
			vld_s29 <= 1'b0;
		end else begin
			if (rdy_s1)  vld_s1  <= s_axis_tvalid;
			if (rdy_s2)  vld_s2  <= vld_s1;
			if (rdy_s3)  vld_s3  <= vld_s2;
			if (rdy_s28) vld_s28 <= cell_valid[NCELL];
			if (rdy_s29) vld_s29 <= vld_s28;
		end
	end

	// Stage 1: magnitudes and quadrant flags.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && rdy_s1) begin
			ax_s1         <= xs[COORD_WIDTH-1] ? COORD_WIDTH'(-xs) : COORD_WIDTH'(xs);
			ay_s1         <= ys[COORD_WIDTH-1] ? COORD_WIDTH'(-ys) : COORD_WIDTH'(ys);
			flg_s1.x_zero <= (xs == '0);
			flg_s1.x_neg  <= xs[COORD_WIDTH-1];
			flg_s1.y_zero <= (ys == '0);
			flg_s1.y_neg  <= ys[COORD_WIDTH-1];
			flg_s1.origin <= (xs == '0) && (ys == '0);
		end
	end

	// Stage 2: squares for the radius.
	always_ff @(posedge clk) begin
		if (vld_s1 && rdy_s2) begin
			sqx_s2 <= (2 * COORD_WIDTH)'(ax_s1) * (2 * COORD_WIDTH)'(ax_s1);
			sqy_s2 <= (2 * COORD_WIDTH)'(ay_s1) * (2 * COORD_WIDTH)'(ay_s1);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			flg_s2 <= flg_s1;
		end
	end

	// Stage 3: start values of the cell chain.
	always_comb begin
		init.cx      = signed'(CORD_W'(ax_s2) << CORDIC_PRESHIFT);
		init.cy      = signed'(CORD_W'(ay_s2) << CORDIC_PRESHIFT);
		init.acc     = '0;
		init.sq_bits = (SQ_W'(sqx_s2) + SQ_W'(sqy_s2)) << (2 * FRAC_BITS);
		init.rem     = '0;
		init.root    = '0;
		init.flags   = flg_s2;
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && rdy_s3) begin
			data_s3 <= init;
		end
	end

	assign cell_valid[0] = vld_s3;
	assign cell_data[0]  = data_s3;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		c2p_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(k)),
			.in_valid  (cell_valid[k]),
			.in_ready  (cell_ready[k]),
			.in_data   (cell_data[k]),
			.out_valid (cell_valid[k+1]),
			.out_ready (cell_ready[k+1]),
			.out_data  (cell_data[k+1])
		);
	end

	assign cell_ready[NCELL] = rdy_s28;
	assign last              = cell_data[NCELL];

	// Stage 28: clamp the first-quadrant angle, map the quadrant, round the root.
	always_comb begin
		if (last.flags.y_zero || last.acc[ACC_W-1]) begin
			t_clamp = '0;
		end else if (last.acc > ACC_DEG90) begin
			t_clamp = TOT_W'(ACC_DEG90);
		end else begin
			t_clamp = TOT_W'(last.acc);
		end
		priority if (!last.flags.x_neg && !last.flags.y_neg) begin
			total = t_clamp;
		end else if (!last.flags.x_neg) begin
			total = TOT_DEG360 - t_clamp;
		end else if (!last.flags.y_neg) begin
			total = TOT_DEG180 - t_clamp;
		end else begin
			total = TOT_DEG180 + t_clamp;
		end
		rad_rnd = RADIUS_W'({1'b0, last.root} +
			(ROOT_W + 1)'(last.rem > REM_W'(last.root)));
	end

	always_ff @(posedge clk) begin
		if (cell_valid[NCELL] && rdy_s28) begin
			tot_s28 <= total;
			rad_s28 <= rad_rnd;
			flg_s28 <= last.flags;
		end
	end

	// Stage 29: round the angle, wrap a full turn, apply the axis and origin cases.
	assign tot_half = {1'b0, tot_s28} + RND_HALF;
	assign ang_rnd  = RND_W'(tot_half >> RND_SH);
	assign ang_wrap = (ang_rnd >= OUT_DEG360) ? ang_rnd - OUT_DEG360 : ang_rnd;

	always_comb begin
		priority if (flg_s28.origin) begin
			ang_fin = '0;
		end else if (flg_s28.x_zero) begin
			ang_fin = flg_s28.y_neg ? OUT_DEG270 : OUT_DEG90;
		end else begin
			ang_fin = ANGLE_W'(ang_wrap);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s28 && rdy_s29) begin
			radius_s29 <= flg_s28.origin ? '0 : rad_s28;
			angle_s29  <= ang_fin;
			err_s29    <= flg_s28.origin;
		end
	end

	assign m_axis_tvalid = vld_s29;
	assign m_axis_tdata  = OUT_TDATA_W'({angle_s29, radius_s29});
	assign m_axis_tuser  = err_s29;

	`C2P_ASSERT_NOW(a_origin_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata == '0, "origin result carries nonzero radius or angle")
	`C2P_ASSERT_NOW(a_angle_range, clk, arst_n, m_axis_tvalid,
		angle_s29 < ANGLE_W'(OUT_DEG360), "angle reached a full turn")
	`C2P_ASSERT_NOW(a_empty_ready, clk, arst_n, !vld_s1, s_axis_tready,
		"empty entry stage refused a request")
	`C2P_ASSERT_NEXT(a_drain, clk, arst_n, m_axis_tvalid && m_axis_tready && !vld_s28,
		!m_axis_tvalid, "result repeated after it was taken")

endmodule

>>> sv/c2p_cell.sv
`timescale 1ns / 1ps
module c2p_cell
	import c2p_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  logic             in_valid,
	output logic             in_ready,
	input  c2p_cell_t        in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output c2p_cell_t        out_data
);

	logic                     valid_q;
	c2p_cell_t                data_q;
	c2p_cell_t                nxt;
	logic                     rot_en;
	logic                     root_en;
	logic                     cy_neg;
	logic signed [CORD_W-1:0] mag_cy;
	logic signed [CORD_W-1:0] shx;
	logic signed [CORD_W-1:0] shy;
	logic [REM_W-1:0]         cur;
	logic [REM_W-1:0]         trial;

	assign rot_en  = {1'b0, idx} < (IDX_W + 1)'(CORDIC_STEPS);
	assign root_en = {1'b0, idx} < (IDX_W + 1)'(ROOT_W);

	// The remainder stays below 2^ROOT_W, so its top two bits are free to drop.
	assign cur   = {in_data.rem[REM_W-3:0], in_data.sq_bits[SQ_W-1 -: 2]};
	assign trial = {in_data.root, 2'b01};

	// cx never goes negative; cy is shifted by magnitude so it truncates toward zero.
	assign cy_neg = in_data.cy[CORD_W-1];
	assign mag_cy = cy_neg ? -in_data.cy : in_data.cy;
	assign shx    = mag_cy >>> idx;
	assign shy    = in_data.cx >>> idx;

	always_comb begin
		nxt = in_data;
		if (rot_en) begin
			nxt.cx = in_data.cx + shx;
			if (cy_neg) begin
				nxt.cy  = in_data.cy + shy;
				nxt.acc = in_data.acc - atan_deg(idx);
			end else begin
				nxt.cy  = in_data.cy - shy;
				nxt.acc = in_data.acc + atan_deg(idx);
			end
		end
		if (root_en) begin
			nxt.sq_bits = in_data.sq_bits << 2;
			if (cur >= trial) begin
				nxt.rem  = cur - trial;
				nxt.root = {in_data.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = cur;
				nxt.root = {in_data.root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import c2p_pkg::*;

	localparam int N_RANDOM     = 1400;
	localparam int QUIET_ITEMS  = 200;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 10;

	localparam int        Q16_FRAC = 16;
	localparam int        PRESHIFT = 20;
	localparam int        N_ROT    = 21;
	localparam longint    DEG90    = 90;
	localparam longint    DEG180   = 180;
	localparam longint    DEG270   = 270;
	localparam longint    DEG360   = 360;
	localparam longint    ATAN_Q16 [N_ROT] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
		29335, 14668, 7334, 3667, 1833, 917, 458,
		229, 115, 57, 29, 14, 7, 4
	};

	typedef struct packed {
		logic [RADIUS_W-1:0] radius;
		logic [ANGLE_W-1:0]  angle;
		logic                origin;
	} polar_t;

	typedef struct packed {
		logic [IN_TDATA_W-1:0] point;
		polar_t                want;
	} polar_expect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	logic [IN_TDATA_W-1:0] point_q [$];
	polar_expect_t polar_expected_q [$];

	int n_accepted = 0;
	int n_checked = 0;
	int total_planned = 0;
	int n_errors = 0;
	int n_reported = 0;
	int cycle_count = 0;

	cartesian_to_polar_degrees_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Nearest integer to sqrt(n), computed one result bit at a time.
	function automatic longint unsigned sqrt_nearest(input longint unsigned n);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned b;
		rem = n;
		root = 0;
		b = 64'd1 << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		if (rem > root)
			root = root + 1;
		return root;
	endfunction

	// Arithmetic right shift that rounds toward zero instead of down.
	function automatic longint shift_toward_zero(input longint v, input int s);
		if (v >= 0)
			return v >>> s;
		return -((-v) >>> s);
	endfunction

	// First-quadrant angle of (ax, ay) in degrees, 16 fraction bits, ax > 0.
	function automatic longint first_quadrant_deg(input longint ax, input longint ay);
		longint cx;
		longint cy;
		longint acc;
		longint sx;
		longint sy;
		cx = ax <<< PRESHIFT;
		cy = ay <<< PRESHIFT;
		acc = 0;
		for (int i = 0; i < N_ROT; i++) begin
			sx = shift_toward_zero(cy, i);
			sy = shift_toward_zero(cx, i);
			if (cy >= 0) begin
				cx = cx + sx;
				cy = cy - sy;
				acc = acc + ATAN_Q16[i];
			end else begin
				cx = cx - sx;
				cy = cy + sy;
				acc = acc - ATAN_Q16[i];
			end
		end
		if (acc < 0)
			acc = 0;
		if (acc > (DEG90 <<< Q16_FRAC))
			acc = DEG90 <<< Q16_FRAC;
		return acc;
	endfunction

	function automatic polar_t to_polar(input logic signed [COORD_FIELD_W-1:0] x,
			input logic signed [COORD_FIELD_W-1:0] y);
		polar_t r;
		longint px;
		longint py;
		longint ax;
		longint ay;
		longint t;
		longint total;
		longint ang;
		px = longint'(x);
		py = longint'(y);
		ax = (px < 0) ? -px : px;
		ay = (py < 0) ? -py : py;
		r = '0;
		if (px == 0 && py == 0) begin
			r.origin = 1'b1;
			return r;
		end
		r.radius = RADIUS_W'(sqrt_nearest(longint'(ax * ax + ay * ay) << (2 * FRAC_BITS)));
		if (px == 0) begin
			ang = ((py > 0) ? DEG90 : DEG270) <<< FRAC_BITS;
		end else begin
			t = (py == 0) ? 0 : first_quadrant_deg(ax, ay);
			if (px > 0)
				total = (py >= 0) ? t : (DEG360 <<< Q16_FRAC) - t;
			else
				total = (py >= 0) ? (DEG180 <<< Q16_FRAC) - t : (DEG180 <<< Q16_FRAC) + t;
			ang = (total + (longint'(1) <<< (Q16_FRAC - FRAC_BITS - 1)))
				>>> (Q16_FRAC - FRAC_BITS);
			// A value that rounds up to a full turn folds back to zero.
			if (ang >= (DEG360 <<< FRAC_BITS))
				ang = ang - (DEG360 <<< FRAC_BITS);
		end
		r.angle = ANGLE_W'(ang);
		return r;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_point(input int x, input int y);
		return {16'(y), 16'(x)};
	endfunction

	function automatic int pick_extreme();
		int v;
		case ($urandom_range(0, 6))
			0: v = -32768;
			1: v = -32767;
			2: v = -1;
			3: v = 0;
			4: v = 1;
			5: v = 32766;
			default: v = 32767;
		endcase
		return v;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] random_point();
		int x;
		int y;
		logic [31:0] r;
		r = $urandom;
		x = int'($signed(r[15:0]));
		y = int'($signed(r[31:16]));
		case ($urandom_range(0, 9))
			4: begin
				x = int'($urandom_range(0, 16)) - 8;
				y = int'($urandom_range(0, 16)) - 8;
			end
			5: begin
				if ($urandom_range(0, 1) == 0)
					x = 0;
				else
					y = 0;
			end
			6: begin
				// Points on the diagonals.
				y = ($urandom_range(0, 1) == 0) ? x : -x;
			end
			7: begin
				x = pick_extreme();
				y = pick_extreme();
			end
			8: begin
				// Nearly on an axis, where the full-turn fold and tiny angles show up.
				if ($urandom_range(0, 1) == 0)
					y = int'($urandom_range(0, 6)) - 3;
				else
					x = int'($urandom_range(0, 6)) - 3;
			end
			9: begin
				y = y >>> $urandom_range(0, 15);
			end
			default: ;
		endcase
		return pack_point(x, y);
	endfunction

	// Request driver: holds each request until accepted, with bursts of idle cycles between.
	int src_gap = 0;
	bit src_idle_on = 1'b1;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if ($urandom_range(0, 255) == 0)
				src_idle_on = !src_idle_on;
			if (s_axis_tvalid && s_axis_tready) begin
				polar_expected_q.push_back('{s_axis_tdata,
					to_polar(s_axis_tdata[15:0], s_axis_tdata[31:16])});
				n_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (point_q.size() != 0) begin
					s_axis_tdata <= point_q.pop_front();
					s_axis_tvalid <= 1'b1;
					if (src_idle_on && n_accepted + QUIET_ITEMS < total_planned &&
							$urandom_range(0, 5) == 0)
						src_gap = $urandom_range(1, 14);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and output backpressure.
	int sink_gap = 0;
	bit sink_stall_on = 1'b1;
	always @(posedge clk or negedge arst_n) begin
		polar_t got;
		polar_expect_t exp_item;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 255) == 0)
				sink_stall_on = !sink_stall_on;
			if (m_axis_tvalid && m_axis_tready) begin
				got.radius = m_axis_tdata[23:0];
				got.angle = m_axis_tdata[40:24];
				got.origin = m_axis_tuser;
				n_checked++;
				if (polar_expected_q.size() == 0) begin
					n_errors++;
					if (n_reported < MAX_REPORTS) begin
						n_reported++;
						$display("ERROR: unexpected result radius=%0d angle=%0d origin=%0d",
							got.radius, got.angle, got.origin);
					end
				end else begin
					exp_item = polar_expected_q.pop_front();
					if (got !== exp_item.want) begin
						n_errors++;
						if (n_reported < MAX_REPORTS) begin
							n_reported++;
							$display("ERROR: x=%0d y=%0d expected radius=%0d angle=%0d origin=%0d",
								$signed(exp_item.point[15:0]), $signed(exp_item.point[31:16]),
								exp_item.want.radius, exp_item.want.angle,
								exp_item.want.origin);
							$display("       got radius=%0d angle=%0d origin=%0d",
								got.radius, got.angle, got.origin);
						end
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (sink_stall_on && n_checked + QUIET_ITEMS < total_planned &&
						$urandom_range(0, 5) == 0)
					sink_gap = $urandom_range(1, 14);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic wait_all_done();
		while (point_q.size() != 0 || s_axis_tvalid || polar_expected_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		// Axes, corners, unit points, the origin and a point that rounds to a full turn.
		point_q.push_back(pack_point(0, 0));
		point_q.push_back(pack_point(1, 0));
		point_q.push_back(pack_point(-1, 0));
		point_q.push_back(pack_point(0, 1));
		point_q.push_back(pack_point(0, -1));
		point_q.push_back(pack_point(32767, 0));
		point_q.push_back(pack_point(-32768, 0));
		point_q.push_back(pack_point(0, 32767));
		point_q.push_back(pack_point(0, -32768));
		point_q.push_back(pack_point(32767, 32767));
		point_q.push_back(pack_point(-32768, -32768));
		point_q.push_back(pack_point(32767, -32768));
		point_q.push_back(pack_point(-32768, 32767));
		point_q.push_back(pack_point(1, 1));
		point_q.push_back(pack_point(-1, 1));
		point_q.push_back(pack_point(-1, -1));
		point_q.push_back(pack_point(1, -1));
		point_q.push_back(pack_point(32767, -1));
		point_q.push_back(pack_point(32767, 1));
		point_q.push_back(pack_point(-32768, -1));
		point_q.push_back(pack_point(-32768, 1));
		point_q.push_back(pack_point(3, 4));
		point_q.push_back(pack_point(-3, -4));
		total_planned = point_q.size() + N_RANDOM;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// The sender stays quiet until every outstanding result has been seen.
		wait_all_done();
		for (int i = 0; i < N_RANDOM / 2; i++)
			point_q.push_back(random_point());
		wait_all_done();
		for (int i = N_RANDOM / 2; i < N_RANDOM; i++)
			point_q.push_back(random_point());
		wait_all_done();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (n_errors == 0 && polar_expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/c2p_pkg.sv
sv/c2p_cell.sv
sv/cartesian_to_polar_degrees_unit.sv
tb/tb_top.sv
